FILE: rtl/core/sht1x_two_wire_master_unit_macros.svh
// assertion helpers for the two-wire master core
`ifndef SHT1X_TWO_WIRE_MASTER_UNIT_MACROS_SVH
`define SHT1X_TWO_WIRE_MASTER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SHT1X_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sht1x core check failed");

// next-cycle implication, checked outside reset
`define SHT1X_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sht1x core check failed");

`endif

FILE: rtl/core/sht1x_pkg.sv
package sht1x_pkg;

    // configuration port
    localparam int CFG_DATA_W = 27;
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_TIMEOUT     = 1'b1;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd800;
    localparam logic [26:0] TIMEOUT_RESET     = 27'd72000000;

    // operation codes
    localparam logic [2:0] OP_TEMP       = 3'd0;
    localparam logic [2:0] OP_HUMI       = 3'd1;
    localparam logic [2:0] OP_STATUS_R   = 3'd2;
    localparam logic [2:0] OP_STATUS_W   = 3'd3;
    localparam logic [2:0] OP_SOFT_RESET = 3'd4;

    // sensor command bytes
    localparam logic [7:0] CMD_TEMP       = 8'h03;
    localparam logic [7:0] CMD_HUMI       = 8'h05;
    localparam logic [7:0] CMD_STATUS_R   = 8'h07;
    localparam logic [7:0] CMD_STATUS_W   = 8'h06;
    localparam logic [7:0] CMD_SOFT_RESET = 8'h1E;

    // sequencer phases
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_CLK_HI  = 5'd1;
    localparam logic [4:0] PH_CLK_LO  = 5'd2;
    localparam logic [4:0] PH_ST0     = 5'd3;
    localparam logic [4:0] PH_ST1     = 5'd4;
    localparam logic [4:0] PH_ST2     = 5'd5;
    localparam logic [4:0] PH_ST3     = 5'd6;
    localparam logic [4:0] PH_ST4     = 5'd7;
    localparam logic [4:0] PH_ST5     = 5'd8;
    localparam logic [4:0] PH_WB_SET  = 5'd9;
    localparam logic [4:0] PH_WB_HI   = 5'd10;
    localparam logic [4:0] PH_WB_LO   = 5'd11;
    localparam logic [4:0] PH_WB_ACK  = 5'd12;
    localparam logic [4:0] PH_WAIT    = 5'd13;
    localparam logic [4:0] PH_RB_PRE  = 5'd14;
    localparam logic [4:0] PH_RB_HI   = 5'd15;
    localparam logic [4:0] PH_RB_ACKD = 5'd16;
    localparam logic [4:0] PH_RB_ACKH = 5'd17;
    localparam logic [4:0] PH_RB_ACKL = 5'd18;

    typedef struct packed {
        logic       sck;
        logic       dat;
        logic       en;
    } sht1x_pins_t;

    typedef struct packed {
        logic       start_req;
        logic [2:0] operation;
        logic [7:0] status_write_value;
        logic       data_in;
    } sht1x_in_t;

    typedef struct packed {
        logic        sck;
        logic        data_out;
        logic        data_enable;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic [7:0]  checksum;
        logic [1:0]  error_count;
    } sht1x_out_t;

endpackage

FILE: rtl/core/sht1x_fsm.sv
`include "sht1x_two_wire_master_unit_macros.svh"

module sht1x_fsm #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  sht1x_pkg::sht1x_in_t  item,
    input  logic [15:0]           half_period,
    input  logic [26:0]           timeout,
    output sht1x_pkg::sht1x_out_t result
);
    import sht1x_pkg::*;

    localparam logic [4:0] RST_CLKS = 5'(RESET_CLOCKS);

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [1:0]  byte_reg, byte_next;
    logic [15:0] delay_reg, delay_next;
    logic [26:0] wait_reg, wait_next;
    logic [15:0] shift_reg, shift_next;
    logic [7:0]  check_reg, check_next;
    logic [1:0]  err_reg, err_next;
    logic [2:0]  op_reg, op_next;
    logic [7:0]  wbyte_reg, wbyte_next;
    sht1x_pins_t pins_reg, pins_next;

    logic        fin;
    logic        go;
    logic [4:0]  go_ph;
    logic [26:0] wait_inc;
    logic [1:0]  err_inc;
    logic [7:0]  tx_byte;
    logic        start_ok;

    // last byte of a read: no acknowledge, goes to the checksum register
    function automatic logic last_read(input logic [1:0] bidx, input logic [2:0] op);
        logic [2:0] cnt;
        cnt = (op == OP_STATUS_R) ? 3'd2 : 3'd3;
        return ({1'b0, bidx} + 3'd1) >= cnt;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [2:0] op);
        logic [7:0] c;
        case (op)
            OP_TEMP:     c = CMD_TEMP;
            OP_HUMI:     c = CMD_HUMI;
            OP_STATUS_R: c = CMD_STATUS_R;
            OP_STATUS_W: c = CMD_STATUS_W;
            default:     c = CMD_SOFT_RESET;
        endcase
        return c;
    endfunction

    assign wait_inc = wait_reg + 27'd1;
    assign err_inc  = (err_reg == 2'd3) ? 2'd3 : err_reg + 2'd1;
    assign start_ok = item.start_req && item.operation <= OP_SOFT_RESET;

    // one tick of the sequencer
    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        delay_next = delay_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        check_next = check_reg;
        err_next   = err_reg;
        op_next    = op_reg;
        wbyte_next = wbyte_reg;
        pins_next  = pins_reg;
        fin        = 1'b0;
        go         = 1'b0;
        go_ph      = PH_IDLE;
        tx_byte    = '0;

        if (phase_reg == PH_IDLE) begin
            if (start_ok) begin
                op_next    = item.operation;
                wbyte_next = item.status_write_value;
                shift_next = '0;
                check_next = '0;
                err_next   = '0;
                wait_next  = '0;
                bit_next   = '0;
                byte_next  = '0;
                go         = 1'b1;
                go_ph      = (item.operation == OP_SOFT_RESET) ? PH_CLK_HI : PH_ST0;
            end
        end else if (phase_reg == PH_WAIT) begin
            // measurement ready wait: low data or timeout starts the read
            if (!item.data_in) begin
                byte_next = '0;
                bit_next  = 4'd7;
                go        = 1'b1;
                go_ph     = PH_RB_PRE;
            end else begin
                wait_next = wait_inc;
                if (wait_inc >= timeout) begin
                    err_next  = err_inc;
                    byte_next = '0;
                    bit_next  = 4'd7;
                    go        = 1'b1;
                    go_ph     = PH_RB_PRE;
                end
            end
        end else if (delay_reg > 16'd1) begin
            delay_next = delay_reg - 16'd1;
        end else begin
            // end of a timed segment
            case (phase_reg)
                PH_CLK_HI: begin
                    go = 1'b1; go_ph = PH_CLK_LO;
                end
                PH_CLK_LO: begin
                    go = 1'b1;
                    if (({1'b0, bit_reg} + 5'd1) >= RST_CLKS) begin
                        go_ph = PH_ST0;
                    end else begin
                        bit_next = bit_reg + 4'd1;
                        go_ph    = PH_CLK_HI;
                    end
                end
                PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4: begin
                    go = 1'b1; go_ph = phase_reg + 5'd1;
                end
                PH_ST5: begin
                    byte_next = '0;
                    bit_next  = 4'd7;
                    go = 1'b1; go_ph = PH_WB_SET;
                end
                PH_WB_SET: begin
                    go = 1'b1; go_ph = PH_WB_HI;
                end
                PH_WB_HI: begin
                    go = 1'b1; go_ph = PH_WB_LO;
                end
                PH_WB_LO: begin
                    go = 1'b1;
                    if (bit_reg == 4'd0) begin
                        go_ph = PH_WB_ACK;
                    end else begin
                        bit_next = bit_reg - 4'd1;
                        go_ph    = PH_WB_SET;
                    end
                end
                PH_WB_ACK: begin
                    if (item.data_in) begin
                        err_next = err_inc;
                    end
                    pins_next.sck = 1'b0;
                    if (op_reg <= OP_HUMI) begin
                        go = 1'b1; go_ph = PH_WAIT;
                    end else if (op_reg == OP_STATUS_R) begin
                        byte_next = '0;
                        bit_next  = 4'd7;
                        go = 1'b1; go_ph = PH_RB_PRE;
                    end else if (op_reg == OP_STATUS_W && byte_reg == 2'd0) begin
                        byte_next = 2'd1;
                        bit_next  = 4'd7;
                        go = 1'b1; go_ph = PH_WB_SET;
                    end else begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        fin        = 1'b1;
                    end
                end
                PH_RB_PRE: begin
                    go = 1'b1; go_ph = PH_RB_HI;
                end
                PH_RB_HI: begin
                    if (last_read(byte_reg, op_reg)) begin
                        check_next = {check_reg[6:0], item.data_in};
                    end else begin
                        shift_next = {shift_reg[14:0], item.data_in};
                    end
                    go = 1'b1;
                    if (bit_reg == 4'd0) begin
                        go_ph = PH_RB_ACKD;
                    end else begin
                        bit_next = bit_reg - 4'd1;
                        go_ph    = PH_RB_PRE;
                    end
                end
                PH_RB_ACKD: begin
                    go = 1'b1; go_ph = PH_RB_ACKH;
                end
                PH_RB_ACKH: begin
                    go = 1'b1; go_ph = PH_RB_ACKL;
                end
                PH_RB_ACKL: begin
                    if (last_read(byte_reg, op_reg)) begin
                        phase_next = PH_IDLE;
                        delay_next = '0;
                        fin        = 1'b1;
                    end else begin
                        byte_next = byte_reg + 2'd1;
                        bit_next  = 4'd7;
                        go = 1'b1; go_ph = PH_RB_PRE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                    fin        = 1'b1;
                end
            endcase
        end

        // entering a segment: load the delay and set the pin levels
        if (go) begin
            phase_next = go_ph;
            delay_next = half_period;
            tx_byte    = (byte_next != 2'd0) ? wbyte_next : cmd_byte(op_next);
            case (go_ph)
                PH_CLK_HI: pins_next = '{sck: 1'b1, dat: 1'b1, en: 1'b1};
                PH_CLK_LO: pins_next.sck = 1'b0;
                PH_ST0:    pins_next = '{sck: 1'b0, dat: 1'b1, en: 1'b1};
                PH_ST1:    pins_next.sck = 1'b1;
                PH_ST2:    pins_next.dat = 1'b0;
                PH_ST3:    pins_next.sck = 1'b0;
                PH_ST4:    pins_next.sck = 1'b1;
                PH_ST5:    pins_next.dat = 1'b1;
                PH_WB_SET: pins_next = '{sck: 1'b0, dat: tx_byte[bit_next[2:0]], en: 1'b1};
                PH_WB_HI:  pins_next.sck = 1'b1;
                PH_WB_LO:  pins_next.sck = 1'b0;
                PH_WB_ACK: begin
                    pins_next.sck = 1'b1;
                    pins_next.en  = 1'b0;
                end
                PH_WAIT: begin
                    pins_next.sck = 1'b0;
                    pins_next.en  = 1'b0;
                    wait_next     = '0;
                end
                PH_RB_PRE: begin
                    pins_next.sck = 1'b0;
                    pins_next.en  = 1'b0;
                end
                PH_RB_HI:  pins_next.sck = 1'b1;
                PH_RB_ACKD: pins_next = '{sck: 1'b0, dat: last_read(byte_next, op_next),
                                          en: 1'b1};
                PH_RB_ACKH: pins_next.sck = 1'b1;
                PH_RB_ACKL: pins_next.sck = 1'b0;
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            bit_reg   <= '0;
            byte_reg  <= '0;
            delay_reg <= '0;
            wait_reg  <= '0;
            shift_reg <= '0;
            check_reg <= '0;
            err_reg   <= '0;
            op_reg    <= '0;
            wbyte_reg <= '0;
            pins_reg  <= '{sck: 1'b0, dat: 1'b1, en: 1'b1};
        end else if (step_en) begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            delay_reg <= delay_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            check_reg <= check_next;
            err_reg   <= err_next;
            op_reg    <= op_next;
            wbyte_reg <= wbyte_next;
            pins_reg  <= pins_next;
        end
    end

    // result of this tick
    always_comb begin
        result.sck         = pins_next.sck;
        result.data_out    = pins_next.dat;
        result.data_enable = pins_next.en;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = fin;
        result.read_value  = shift_next;
        result.checksum    = check_next;
        result.error_count = err_next;
    end

    // checks
    `SHT1X_ASSERT_IMP(a_done_not_busy, result.done_res, !result.busy_res)
    `SHT1X_ASSERT_NXT(a_idle_holds, step_en && phase_reg == PH_IDLE && !start_ok, phase_reg == PH_IDLE)
    `SHT1X_ASSERT_NXT(a_state_holds_when_stalled, !step_en, $stable(phase_reg) && $stable(pins_reg))
    `SHT1X_ASSERT_IMP(a_error_bound, step_en, err_next != 2'd3)

endmodule

FILE: rtl/core/sht1x_two_wire_master_unit.sv
// Two-wire master for an SHT1x-type sensor. Every input transaction is one tick: it
// carries a start request, an operation, the status byte to write and the sampled
// DATA level, and yields exactly one result transaction with the SCK/DATA pin levels,
// busy/done flags, the received word, checksum and error count after that tick. One
// transaction is taken per clock while the output is not stalled; the input register
// loads the accepted tick, the sequencer step goes into the output register once that
// register is free, and while a result waits there the input register can take one
// more tick. Pin timing is
// in units of half_period_ticks ticks (register 0); the ready wait after a measure
// command lasts at most ready_timeout_ticks ticks (register 1). Write the
// configuration only while no transfer is in progress.
module sht1x_two_wire_master_unit #(
    parameter int RESET_CLOCKS = 9
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sht1x_pkg::sht1x_in_t                s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sht1x_pkg::sht1x_out_t               m_payload,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [sht1x_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sht1x_pkg::*;

    logic        in_valid_reg, in_valid_next;
    sht1x_in_t   in_payload_reg;
    logic        out_valid_reg, out_valid_next;
    sht1x_out_t  out_payload_reg;
    sht1x_out_t  step_result;
    logic [15:0] half_period_reg;
    logic [26:0] timeout_reg;
    logic        advance;

    // handshake between input register and output register
    assign advance       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_HALF_PERIOD) begin
                half_period_reg <= cfg_data[15:0];
            end else begin
                timeout_reg <= cfg_data[26:0];
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_payload_reg <= s_payload;
        end
    end

    // sequencer
    sht1x_fsm #(
        .RESET_CLOCKS (RESET_CLOCKS)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_payload_reg),
        .half_period (half_period_reg),
        .timeout     (timeout_reg),
        .result      (step_result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_payload_reg <= step_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_payload_reg;

endmodule

FILE: tb/sht1x_two_wire_master_unit_test.sv
`timescale 1ns / 100ps

module sht1x_two_wire_master_unit_test;
    import sht1x_pkg::*;

    localparam int SOFT_RESET_PULSES = 9;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam logic [26:0] TIMEOUT_MAX = 27'h7FFFFFF;

    typedef enum {ACK_ALWAYS, ACK_NEVER, ACK_MOSTLY} ack_mode_e;
    typedef enum {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_e;

    // sequencer state plus its configuration
    typedef struct {
        bit [4:0]    phase;
        bit [3:0]    bit_idx;
        bit [1:0]    byte_idx;
        bit [15:0]   delay_left;
        bit [26:0]   ready_wait;
        bit [15:0]   word;
        bit [7:0]    crc;
        bit [1:0]    errors;
        bit [2:0]    op;
        bit [7:0]    wr_byte;
        sht1x_pins_t pins;
        bit          done;
        bit [15:0]   half_period;
        bit [26:0]   timeout;
    } bus_state_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sht1x_in_t             s_payload = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sht1x_out_t            m_payload;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model_bus follows accepted ticks, plan_bus runs ahead for stimulus shaping
    bus_state_t model_bus;
    bus_state_t plan_bus;
    sht1x_in_t  stim_q[$];
    sht1x_out_t result_q[$];
    int         queued_total = 0;
    int         accepted_total = 0;
    int         fail_total = 0;
    int         hold_requests = 0;
    int         holds_served = 0;
    bit         quiet_run = 1'b0;

    // driver and monitor working variables
    sht1x_in_t  next_item;
    sht1x_out_t predicted;
    sht1x_out_t want;
    int         gap_left = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    logic       next_ready;

    sht1x_two_wire_master_unit #(
        .RESET_CLOCKS(SOFT_RESET_PULSES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // sequencer predictor
    function automatic bus_state_t bus_reset();
        bus_state_t st;
        st = '{default: '0};
        st.pins = '{sck: 1'b0, dat: 1'b1, en: 1'b1};
        st.half_period = HALF_PERIOD_RESET;
        st.timeout = TIMEOUT_RESET;
        return st;
    endfunction

    function automatic bit [7:0] command_byte(bus_state_t st);
        if (st.byte_idx != 2'd0) return st.wr_byte;
        case (st.op)
            OP_TEMP: return CMD_TEMP;
            OP_HUMI: return CMD_HUMI;
            OP_STATUS_R: return CMD_STATUS_R;
            OP_STATUS_W: return CMD_STATUS_W;
            default: return CMD_SOFT_RESET;
        endcase
    endfunction

    function automatic bit on_last_read(bus_state_t st);
        return (int'(st.byte_idx) + 1) >= ((st.op == OP_STATUS_R) ? 2 : 3);
    endfunction

    function automatic void count_error(inout bus_state_t st);
        if (st.errors != 2'd3) st.errors = st.errors + 2'd1;
    endfunction

    function automatic void end_exchange(inout bus_state_t st);
        st.phase = PH_IDLE;
        st.delay_left = '0;
        st.done = 1'b1;
    endfunction

    // pin levels of a segment show on the tick it is entered
    function automatic void enter_segment(inout bus_state_t st, input bit [4:0] ph);
        bit       level;
        bit [7:0] level_byte;
        st.phase = ph;
        st.delay_left = st.half_period;
        case (ph)
            PH_CLK_HI: st.pins = '{sck: 1'b1, dat: 1'b1, en: 1'b1};
            PH_CLK_LO, PH_ST3, PH_WB_LO, PH_RB_ACKL: st.pins.sck = 1'b0;
            PH_ST0: st.pins = '{sck: 1'b0, dat: 1'b1, en: 1'b1};
            PH_ST1, PH_ST4, PH_WB_HI, PH_RB_HI, PH_RB_ACKH: st.pins.sck = 1'b1;
            PH_ST2: st.pins.dat = 1'b0;
            PH_ST5: st.pins.dat = 1'b1;
            PH_WB_SET: begin
                level_byte = command_byte(st);
                level = level_byte[st.bit_idx[2:0]];
                st.pins = '{sck: 1'b0, dat: level, en: 1'b1};
            end
            PH_WB_ACK: begin
                st.pins.sck = 1'b1;
                st.pins.en = 1'b0;
            end
            PH_WAIT: begin
                st.pins.sck = 1'b0;
                st.pins.en = 1'b0;
                st.ready_wait = '0;
            end
            PH_RB_PRE: begin
                st.pins.sck = 1'b0;
                st.pins.en = 1'b0;
            end
            PH_RB_ACKD: st.pins = '{sck: 1'b0, dat: on_last_read(st), en: 1'b1};
            default: ;
        endcase
    endfunction

    function automatic void start_read(inout bus_state_t st);
        st.byte_idx = 2'd0;
        st.bit_idx = 4'd7;
        enter_segment(st, PH_RB_PRE);
    endfunction

    // last tick of a segment: sample and move on
    function automatic void close_segment(inout bus_state_t st, input bit din);
        case (st.phase)
            PH_CLK_HI: enter_segment(st, PH_CLK_LO);
            PH_CLK_LO: begin
                if (int'(st.bit_idx) + 1 >= SOFT_RESET_PULSES) begin
                    enter_segment(st, PH_ST0);
                end else begin
                    st.bit_idx = st.bit_idx + 4'd1;
                    enter_segment(st, PH_CLK_HI);
                end
            end
            PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_ST4: enter_segment(st, st.phase + 5'd1);
            PH_ST5: begin
                st.byte_idx = 2'd0;
                st.bit_idx = 4'd7;
                enter_segment(st, PH_WB_SET);
            end
            PH_WB_SET: enter_segment(st, PH_WB_HI);
            PH_WB_HI: enter_segment(st, PH_WB_LO);
            PH_WB_LO: begin
                if (st.bit_idx == 4'd0) begin
                    enter_segment(st, PH_WB_ACK);
                end else begin
                    st.bit_idx = st.bit_idx - 4'd1;
                    enter_segment(st, PH_WB_SET);
                end
            end
            PH_WB_ACK: begin
                if (din) count_error(st);
                st.pins.sck = 1'b0;
                if (st.op <= OP_HUMI) begin
                    enter_segment(st, PH_WAIT);
                end else if (st.op == OP_STATUS_R) begin
                    start_read(st);
                end else if (st.op == OP_STATUS_W && st.byte_idx == 2'd0) begin
                    st.byte_idx = 2'd1;
                    st.bit_idx = 4'd7;
                    enter_segment(st, PH_WB_SET);
                end else begin
                    end_exchange(st);
                end
            end
            PH_RB_PRE: enter_segment(st, PH_RB_HI);
            PH_RB_HI: begin
                if (on_last_read(st)) st.crc = {st.crc[6:0], din};
                else st.word = {st.word[14:0], din};
                if (st.bit_idx == 4'd0) begin
                    enter_segment(st, PH_RB_ACKD);
                end else begin
                    st.bit_idx = st.bit_idx - 4'd1;
                    enter_segment(st, PH_RB_PRE);
                end
            end
            PH_RB_ACKD: enter_segment(st, PH_RB_ACKH);
            PH_RB_ACKH: enter_segment(st, PH_RB_ACKL);
            PH_RB_ACKL: begin
                if (on_last_read(st)) begin
                    end_exchange(st);
                end else begin
                    st.byte_idx = st.byte_idx + 2'd1;
                    st.bit_idx = 4'd7;
                    enter_segment(st, PH_RB_PRE);
                end
            end
            default: end_exchange(st);
        endcase
    endfunction

    // one tick of the sequencer and the outputs it leaves
    function automatic void bus_tick(inout bus_state_t st, input sht1x_in_t tick,
                                     output sht1x_out_t res);
        st.done = 1'b0;
        if (st.phase == PH_IDLE) begin
            if (tick.start_req && tick.operation <= OP_SOFT_RESET) begin
                st.op = tick.operation;
                st.wr_byte = tick.status_write_value;
                st.word = '0;
                st.crc = '0;
                st.errors = '0;
                st.ready_wait = '0;
                st.bit_idx = '0;
                st.byte_idx = '0;
                enter_segment(st, (tick.operation == OP_SOFT_RESET) ? PH_CLK_HI : PH_ST0);
            end
        end else if (st.phase == PH_WAIT) begin
            if (!tick.data_in) begin
                start_read(st);
            end else begin
                st.ready_wait = st.ready_wait + 27'd1;
                if (st.ready_wait >= st.timeout) begin
                    count_error(st);
                    start_read(st);
                end
            end
        end else if (st.delay_left > 16'd1) begin
            st.delay_left = st.delay_left - 16'd1;
        end else begin
            close_segment(st, tick.data_in);
        end
        res.sck = st.pins.sck;
        res.data_out = st.pins.dat;
        res.data_enable = st.pins.en;
        res.busy_res = (st.phase != PH_IDLE);
        res.done_res = st.done;
        res.read_value = st.word;
        res.checksum = st.crc;
        res.error_count = st.errors;
    endfunction

    // stimulus building, shaped by the look-ahead copy
    function automatic void push_tick(input sht1x_in_t tick);
        sht1x_out_t unused;
        bus_tick(plan_bus, tick, unused);
        stim_q.push_back(tick);
        queued_total++;
    endfunction

    // idle ticks: a start only with an unknown operation
    function automatic sht1x_in_t noise_tick();
        sht1x_in_t t;
        t.operation = 3'($urandom_range(0, 7));
        t.start_req = (t.operation > OP_SOFT_RESET) ? 1'($urandom_range(0, 1)) : 1'b0;
        t.status_write_value = 8'($urandom);
        t.data_in = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // one full transaction with a sensor answering on DATA
    task automatic run_exchange(input logic [2:0] op, input logic [7:0] wval,
                                input int ready_delay, input ack_mode_e acks,
                                input fill_e fill);
        sht1x_in_t t;
        int waited;
        waited = 0;
        t.start_req = 1'b1;
        t.operation = op;
        t.status_write_value = wval;
        t.data_in = 1'($urandom_range(0, 1));
        push_tick(t);
        while (plan_bus.phase != PH_IDLE) begin
            t.start_req = 1'($urandom_range(0, 1));
            t.operation = 3'($urandom_range(0, 7));
            t.status_write_value = 8'($urandom);
            t.data_in = 1'($urandom_range(0, 1));
            case (plan_bus.phase)
                PH_WB_ACK: begin
                    case (acks)
                        ACK_ALWAYS: t.data_in = 1'b0;
                        ACK_NEVER: t.data_in = 1'b1;
                        default: t.data_in = ($urandom_range(0, 7) == 0);
                    endcase
                end
                PH_WAIT: begin
                    waited++;
                    t.data_in = (waited <= ready_delay);
                end
                PH_RB_HI: begin
                    if (fill == FILL_ZEROS) t.data_in = 1'b0;
                    else if (fill == FILL_ONES) t.data_in = 1'b1;
                end
                default: ;
            endcase
            push_tick(t);
        end
    endtask

    task automatic drain();
        while (!(accepted_total == queued_total && result_q.size() == 0)) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_HALF_PERIOD) begin
            model_bus.half_period = value[15:0];
            plan_bus.half_period = value[15:0];
        end else begin
            model_bus.timeout = value[26:0];
            plan_bus.timeout = value[26:0];
        end
    endtask

    // random transactions under one register setting
    task automatic run_phase(input logic [15:0] half, input logic [26:0] limit,
                             input int target, input bit with_hold);
        int first;
        drain();
        write_reg(REG_HALF_PERIOD, CFG_DATA_W'(half));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(limit));
        first = queued_total;
        while (queued_total - first < target) begin
            run_exchange(3'($urandom_range(0, 4)), 8'($urandom), $urandom_range(0, 60),
                         ACK_MOSTLY, FILL_RANDOM);
            repeat ($urandom_range(0, 3)) push_tick(noise_tick());
        end
        if (with_hold) hold_requests++;
        drain();
    endtask

    // driver: offers queued ticks, predicts each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bus_tick(model_bus, s_payload, predicted);
                result_q.push_back(predicted);
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 3);
                    s_valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    next_item = stim_q.pop_front();
                    s_payload <= next_item;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic int field_mismatch(input string name, input logic [15:0] exp_val,
                                          input logic [15:0] act_val);
        if (exp_val === act_val) return 0;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
        return 1;
    endfunction

    // monitor: checks each result transaction, stalls at random and for requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time,
                             m_payload);
                    fail_total++;
                end else begin
                    want = result_q.pop_front();
                    fail_total += field_mismatch("sck", 16'(want.sck),
                                                 16'(m_payload.sck));
                    fail_total += field_mismatch("data_out", 16'(want.data_out),
                                                 16'(m_payload.data_out));
                    fail_total += field_mismatch("data_enable", 16'(want.data_enable),
                                                 16'(m_payload.data_enable));
                    fail_total += field_mismatch("busy_res", 16'(want.busy_res),
                                                 16'(m_payload.busy_res));
                    fail_total += field_mismatch("done_res", 16'(want.done_res),
                                                 16'(m_payload.done_res));
                    fail_total += field_mismatch("read_value", want.read_value,
                                                 m_payload.read_value);
                    fail_total += field_mismatch("checksum", 16'(want.checksum),
                                                 16'(m_payload.checksum));
                    fail_total += field_mismatch("error_count", 16'(want.error_count),
                                                 16'(m_payload.error_count));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_ready <= next_ready;
        end
    end

    // main sequence
    initial begin
        model_bus = bus_reset();
        plan_bus = bus_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset pin levels, unknown operations ignored
        repeat (3) push_tick(noise_tick());
        push_tick('{start_req: 1'b1, operation: 3'd7, status_write_value: 8'hFF,
                    data_in: 1'b1});
        drain();

        // zero half period and zero timeout, every operation at least once
        write_reg(REG_HALF_PERIOD, '0);
        write_reg(REG_TIMEOUT, '0);
        run_exchange(OP_TEMP, 8'h00, 0, ACK_ALWAYS, FILL_ONES);
        push_tick(noise_tick());
        run_exchange(OP_HUMI, 8'hFF, 3, ACK_ALWAYS, FILL_ZEROS);
        run_exchange(OP_STATUS_R, 8'h00, 0, ACK_NEVER, FILL_ONES);
        push_tick(noise_tick());
        run_exchange(OP_STATUS_W, 8'hFF, 0, ACK_NEVER, FILL_RANDOM);
        run_exchange(OP_STATUS_W, 8'h00, 0, ACK_ALWAYS, FILL_RANDOM);
        run_exchange(OP_SOFT_RESET, 8'hA5, 0, ACK_ALWAYS, FILL_RANDOM);
        // missing acknowledge plus ready timeout
        run_exchange(OP_TEMP, 8'h5A, 100, ACK_NEVER, FILL_ZEROS);
        drain();

        run_phase(16'd1, 27'd1, 40, 1'b0);
        run_phase(16'd2, 27'd40, 60, 1'b1);
        run_phase(16'd3, TIMEOUT_MAX, 100, 1'b0);
        run_phase(16'd1, 27'd6, 40, 1'b1);
        quiet_run = 1'b1;
        run_phase(16'd0, 27'd25, 40, 1'b0);

        // longest half period: first segment held while ticks keep coming
        write_reg(REG_HALF_PERIOD, CFG_DATA_W'(16'hFFFF));
        push_tick('{start_req: 1'b1, operation: 3'($urandom_range(0, 4)),
                    status_write_value: 8'($urandom), data_in: 1'b1});
        repeat (50) push_tick(noise_tick());
        drain();
        repeat (8) @(posedge aclk);

        if (fail_total == 0 && result_q.size() == 0) begin
            $display("PASS sht1x_two_wire_master_unit");
        end else begin
            $display("FAIL sht1x_two_wire_master_unit");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAIL sht1x_two_wire_master_unit");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/sht1x_pkg.sv
rtl/core/sht1x_fsm.sv
rtl/core/sht1x_two_wire_master_unit.sv
tb/sht1x_two_wire_master_unit_test.sv
